### rtl/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Request codes, status codes and field widths shared by the deque block.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DATA_W = 32;
	localparam int REQ_W  = 3;
	localparam int ST_W   = 2;

	// request codes carried in the input tuser field
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
	localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd5;

	// result status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	// value answered by a pop or peek on an empty queue
	localparam logic [DATA_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

	typedef logic [DATA_W-1:0] data_t;

endpackage

### rtl/dq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// Read data holds its value until the next read enable.
// ----------------------------------------------------------------------------
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values kept in a ring buffer RAM.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one request per word: s_tuser holds the request
//   code (push front/back, pop front/back, peek front/back) and s_tdata the
//   value for pushes. The master channel returns exactly one result word per
//   request, in request order.
//   The result passes the read stage and the output register: the accepting
//   edge updates the head, tail and count registers and issues the RAM
//   access, if any, and the output register, once free, captures the RAM
//   read data with the status. Throughput is one request per cycle while
//   the receiver keeps up; the RAM read is hidden by the read stage, and a
//   push followed by a pop of the same slot is safe: the write lands first.
//   A pop or peek on an empty queue answers -1 with status empty; a push on a
//   full queue is dropped with status full. Codes 6 and 7 do nothing.
//   Reset clears the pointers and the count; the RAM is not cleared, since
//   entries are only read after being written.
//   When the receiver stalls, the output register and the read stage hold
//   up to two results; s_tready falls once both are occupied.
// ----------------------------------------------------------------------------
module double_ended_queue #(
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	// request channel
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [dq_pkg::DATA_W-1:0]   s_tdata,  // [31:0] data_in
	input  logic [dq_pkg::REQ_W-1:0]    s_tuser,  // [2:0] req_type
	// result channel
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [31:0] data_out, [33:32] status, [33+CW:34] count, [34+CW] is_empty
	output logic [((35 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

	import dq_pkg::*;

	localparam int AW      = $clog2(DEPTH);
	localparam int CW      = $clog2(DEPTH + 1);
	localparam int TDATA_W = ((35 + CW + 7) / 8) * 8;
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
	localparam logic [AW-1:0] SLOT_ONE  = AW'(1);
	localparam logic [CW-1:0] CNT_ONE   = CW'(1);

	// pointer state
	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;

	// read stage
	logic            valid_s1, use_mem_s1, empty_s1;
	logic [ST_W-1:0] status_s1;
	logic [CW-1:0]   count_s1;

	// output register
	logic            out_valid_q, out_empty_q;
	data_t           out_data_q;
	logic [ST_W-1:0] out_status_q;
	logic [CW-1:0]   out_count_q;

	// request decode results
	logic [AW-1:0]   nxt_head, nxt_tail, waddr, raddr;
	logic [AW-1:0]   head_prev, head_next, tail_prev, tail_next;
	logic [CW-1:0]   nxt_count;
	logic            wr_req, rd_req, use_mem;
	logic [ST_W-1:0] status;
	logic            q_full, q_empty;
	logic            s_accept, adv_s1;
	data_t           rd_data, data_s1;

	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign s_accept = s_tvalid && s_tready;

	// ring neighbors of the pointers
	assign head_prev = (head_q == '0) ? LAST_SLOT : head_q - SLOT_ONE;
	assign head_next = (head_q == LAST_SLOT) ? '0 : head_q + SLOT_ONE;
	assign tail_prev = (tail_q == '0) ? LAST_SLOT : tail_q - SLOT_ONE;
	assign tail_next = (tail_q == LAST_SLOT) ? '0 : tail_q + SLOT_ONE;
	assign q_full    = (count_q == FULL_CNT);
	assign q_empty   = (count_q == '0);

	// decode the request into pointer moves and at most one RAM access
	always_comb begin
		nxt_head = head_q;
		nxt_tail = tail_q;
		nxt_count = count_q;
		wr_req = 1'b0;
		rd_req = 1'b0;
		use_mem = 1'b0;
		waddr = tail_q;
		raddr = head_q;
		status = ST_OK;
		unique case (s_tuser)
			REQ_PUSH_FRONT: begin
				if (q_full) begin
					status = ST_FULL;
				end else begin
					nxt_head = head_prev;
					waddr = head_prev;
					wr_req = 1'b1;
					nxt_count = count_q + CNT_ONE;
				end
			end
			REQ_PUSH_BACK: begin
				if (q_full) begin
					status = ST_FULL;
				end else begin
					nxt_tail = tail_next;
					waddr = tail_q;
					wr_req = 1'b1;
					nxt_count = count_q + CNT_ONE;
				end
			end
			REQ_POP_FRONT: begin
				if (q_empty) begin
					status = ST_EMPTY;
				end else begin
					raddr = head_q;
					rd_req = 1'b1;
					use_mem = 1'b1;
					nxt_head = head_next;
					nxt_count = count_q - CNT_ONE;
				end
			end
			REQ_POP_BACK: begin
				if (q_empty) begin
					status = ST_EMPTY;
				end else begin
					raddr = tail_prev;
					rd_req = 1'b1;
					use_mem = 1'b1;
					nxt_tail = tail_prev;
					nxt_count = count_q - CNT_ONE;
				end
			end
			REQ_PEEK_FRONT: begin
				if (q_empty) begin
					status = ST_EMPTY;
				end else begin
					raddr = head_q;
					rd_req = 1'b1;
					use_mem = 1'b1;
				end
			end
			REQ_PEEK_BACK: begin
				if (q_empty) begin
					status = ST_EMPTY;
				end else begin
					raddr = tail_prev;
					rd_req = 1'b1;
					use_mem = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	dq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (s_accept && wr_req),
		.waddr(waddr),
		.wdata(s_tdata),
		.re   (s_accept && rd_req),
		.raddr(raddr),
		.rdata(rd_data)
	);

	// advance the pointers on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else if (s_accept) begin
			head_q <= nxt_head;
			tail_q <= nxt_tail;
			count_q <= nxt_count;
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (s_accept) begin
			use_mem_s1 <= use_mem;
			status_s1 <= status;
			count_s1 <= nxt_count;
			empty_s1 <= (nxt_count == '0);
		end
	end

	// pick RAM data or the fixed answer
	assign data_s1 = use_mem_s1 ? rd_data :
		((status_s1 == ST_EMPTY) ? EMPTY_VALUE : '0);

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= data_s1;
			out_status_q <= status_s1;
			out_count_q <= count_s1;
			out_empty_q <= empty_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_W'({out_empty_q, out_count_q, out_status_q, out_data_q});

endmodule
